// ===== rtl/ffpa_pkg.sv =====
package ffpa_pkg;

  // Table geometry
  localparam int MAX_BLOCKS = 64;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = IDX_W + 1;

  // Pool layout
  localparam int OVERHEAD   = 32;
  localparam int ALIGN      = 8;
  localparam int ALIGN_SH   = $clog2(ALIGN);
  localparam int HDR_SKIP   = OVERHEAD - 4;

  localparam int OFF_W      = 20;
  localparam int SIZE_W     = 21;
  localparam int REQ_W      = SIZE_W + 1;

  localparam logic [SIZE_W-1:0] POOL_MAX   = SIZE_W'(1048576);
  localparam logic [SIZE_W-1:0] POOL_RESET = SIZE_W'(65536);

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOFIT    = 2'd1;
  localparam logic [1:0] ST_BAD_ADDR = 2'd2;

  // Request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // One table entry
  typedef struct packed {
    logic [OFF_W-1:0]  off;
    logic [SIZE_W-1:0] size;
    logic              used;
  } entry_t;

  localparam int ENT_W = $bits(entry_t);

  // Table write request
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } tbl_wr_t;

  // Finished transaction handed to the output register
  typedef struct packed {
    logic              valid;
    logic [OFF_W-1:0]  addr;
    logic [1:0]        status;
    logic [SIZE_W-1:0] free_bytes;
    logic [SIZE_W-1:0] used_bytes;
  } result_t;

endpackage

// ===== rtl/ffpa_ram.sv =====
module ffpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/ffpa_ctrl.sv =====
module ffpa_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ffpa_pkg::SIZE_W-1:0]    cfg_wdata,
  input  logic                           in_valid,
  input  logic                           in_kind,
  input  logic [ffpa_pkg::SIZE_W-1:0]    in_req_size,
  input  logic [ffpa_pkg::OFF_W-1:0]     in_addr,
  output logic                           in_stall,
  input  logic                           out_free,
  output ffpa_pkg::result_t              res,
  output logic [ffpa_pkg::IDX_W-1:0]     rd_addr,
  input  ffpa_pkg::entry_t               rd_data,
  output ffpa_pkg::tbl_wr_t              wr
);
  import ffpa_pkg::*;

  localparam logic [4:0] S_INIT   = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_FRD    = 5'd2;
  localparam logic [4:0] S_FCHK   = 5'd3;
  localparam logic [4:0] S_BSEL   = 5'd4;
  localparam logic [4:0] S_BCHK   = 5'd5;
  localparam logic [4:0] S_GRANT  = 5'd6;
  localparam logic [4:0] S_SUP_RD = 5'd7;
  localparam logic [4:0] S_SUP_WR = 5'd8;
  localparam logic [4:0] S_SPL_HI = 5'd9;
  localparam logic [4:0] S_SPL_LO = 5'd10;
  localparam logic [4:0] S_FS_RD  = 5'd11;
  localparam logic [4:0] S_FS_CHK = 5'd12;
  localparam logic [4:0] S_FP_RD  = 5'd13;
  localparam logic [4:0] S_FP_GET = 5'd14;
  localparam logic [4:0] S_FN_RD  = 5'd15;
  localparam logic [4:0] S_FN_GET = 5'd16;
  localparam logic [4:0] S_MERGE  = 5'd17;
  localparam logic [4:0] S_SDN_RD = 5'd18;
  localparam logic [4:0] S_SDN_WR = 5'd19;
  localparam logic [4:0] S_DONE   = 5'd20;

  logic [4:0]        state_r, state_nxt;
  logic [SIZE_W-1:0] pool_r, pool_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [SIZE_W-1:0] free_r, free_nxt;
  logic [SIZE_W-1:0] used_r, used_nxt;
  logic [REQ_W-1:0]  size_r, size_nxt;
  logic [OFF_W-1:0]  start_r, start_nxt;
  logic [CNT_W-1:0]  f_r, f_nxt;
  logic              f_ok_r, f_ok_nxt;
  logic [CNT_W-1:0]  b_r, b_nxt;
  logic              b_ok_r, b_ok_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  j_r, j_nxt;
  logic [1:0]        k_r, k_nxt;
  entry_t            ent_r, ent_nxt;
  logic [SIZE_W-1:0] prev_size_r, prev_size_nxt;
  logic [OFF_W-1:0]  prev_off_r, prev_off_nxt;
  logic [SIZE_W-1:0] next_size_r, next_size_nxt;
  logic              pf_r, pf_nxt;
  logic              nf_r, nf_nxt;
  logic [OFF_W-1:0]  raddr_r, raddr_nxt;
  logic [1:0]        status_r, status_nxt;

  // Shared compare / add unit operands
  logic              fit_c;
  logic              split_c;
  logic [REQ_W:0]    need_c;
  logic [REQ_W-1:0]  round_c;
  logic [SIZE_W-1:0] clamp_c;
  logic [SIZE_W-1:0] s_used_c;

  assign fit_c   = !rd_data.used && ({1'b0, rd_data.size} >= size_r);
  assign need_c  = {1'b0, size_r} + (REQ_W+1)'(OVERHEAD);
  assign split_c = ({2'b00, ent_r.size} >= need_c) && (count_r < CNT_W'(MAX_BLOCKS));
  assign round_c = ((REQ_W'(in_req_size) + REQ_W'(ALIGN - 1)) >> ALIGN_SH) << ALIGN_SH;
  assign s_used_c = ent_r.used ? ent_r.size : '0;

  always_comb begin
    priority if (pool_r < SIZE_W'(OVERHEAD)) begin
      clamp_c = SIZE_W'(OVERHEAD);
    end else if (pool_r > POOL_MAX) begin
      clamp_c = POOL_MAX;
    end else begin
      clamp_c = pool_r;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    pool_nxt      = pool_r;
    count_nxt     = count_r;
    free_nxt      = free_r;
    used_nxt      = used_r;
    size_nxt      = size_r;
    start_nxt     = start_r;
    f_nxt         = f_r;
    f_ok_nxt      = f_ok_r;
    b_nxt         = b_r;
    b_ok_nxt      = b_ok_r;
    idx_nxt       = idx_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    ent_nxt       = ent_r;
    prev_size_nxt = prev_size_r;
    prev_off_nxt  = prev_off_r;
    next_size_nxt = next_size_r;
    pf_nxt        = pf_r;
    nf_nxt        = nf_r;
    raddr_nxt     = raddr_r;
    status_nxt    = status_r;
    rd_addr       = '0;
    wr            = '0;
    res           = '0;

    unique case (state_r)
      S_INIT: begin
        wr.en        = 1'b1;
        wr.addr      = '0;
        wr.data.off  = '0;
        wr.data.size = clamp_c - SIZE_W'(OVERHEAD);
        wr.data.used = 1'b0;
        count_nxt    = CNT_W'(1);
        free_nxt     = clamp_c - SIZE_W'(OVERHEAD);
        used_nxt     = '0;
        state_nxt    = S_IDLE;
      end

      S_IDLE: begin
        if (in_valid) begin
          raddr_nxt  = '0;
          status_nxt = ST_OK;
          if (in_kind == KIND_ALLOC) begin
            size_nxt = round_c;
            f_nxt    = '0;
            f_ok_nxt = 1'b1;
            b_nxt    = count_r - CNT_W'(1);
            b_ok_nxt = 1'b1;
            if (in_req_size == '0) begin
              status_nxt = ST_NOFIT;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_FRD;
            end
          end else begin
            start_nxt = in_addr - OFF_W'(HDR_SKIP);
            j_nxt     = '0;
            if (in_addr < OFF_W'(HDR_SKIP)) begin
              status_nxt = ST_BAD_ADDR;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_FS_RD;
            end
          end
        end
      end

      // Alternating first-fit search
      S_FRD: begin
        rd_addr = f_r[IDX_W-1:0];
        state_nxt = f_ok_r ? S_FCHK : S_BSEL;
      end

      S_FCHK: begin
        if (fit_c) begin
          idx_nxt   = f_r[IDX_W-1:0];
          ent_nxt   = rd_data;
          state_nxt = S_GRANT;
        end else begin
          f_ok_nxt  = (f_r + CNT_W'(1)) < count_r;
          f_nxt     = f_r + CNT_W'(1);
          state_nxt = S_BSEL;
        end
      end

      S_BSEL: begin
        rd_addr = b_r[IDX_W-1:0];
        if (b_ok_r && !(f_ok_r && (b_r == f_r))) begin
          state_nxt = S_BCHK;
        end else if (!f_ok_r && !b_ok_r) begin
          status_nxt = ST_NOFIT;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_FRD;
        end
      end

      S_BCHK: begin
        if (fit_c) begin
          idx_nxt   = b_r[IDX_W-1:0];
          ent_nxt   = rd_data;
          state_nxt = S_GRANT;
        end else begin
          b_ok_nxt = (b_r != '0);
          b_nxt    = b_r - CNT_W'(1);
          if (!f_ok_r && (b_r == '0)) begin
            status_nxt = ST_NOFIT;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_FRD;
          end
        end
      end

      // Grant, with optional split
      S_GRANT: begin
        raddr_nxt = OFF_W'(ent_r.off + OFF_W'(HDR_SKIP));
        if (split_c) begin
          j_nxt     = count_r;
          state_nxt = S_SUP_RD;
        end else begin
          wr.en        = 1'b1;
          wr.addr      = idx_r;
          wr.data      = ent_r;
          wr.data.used = 1'b1;
          used_nxt     = used_r + ent_r.size;
          free_nxt     = free_r - ent_r.size;
          state_nxt    = S_DONE;
        end
      end

      S_SUP_RD: begin
        rd_addr = IDX_W'(j_r - CNT_W'(1));
        if (j_r > ({1'b0, idx_r} + CNT_W'(1))) begin
          state_nxt = S_SUP_WR;
        end else begin
          state_nxt = S_SPL_HI;
        end
      end

      S_SUP_WR: begin
        wr.en     = 1'b1;
        wr.addr   = j_r[IDX_W-1:0];
        wr.data   = rd_data;
        j_nxt     = j_r - CNT_W'(1);
        state_nxt = S_SUP_RD;
      end

      S_SPL_HI: begin
        wr.en        = 1'b1;
        wr.addr      = idx_r + IDX_W'(1);
        wr.data.off  = OFF_W'(need_c + (REQ_W+1)'(ent_r.off));
        wr.data.size = SIZE_W'((REQ_W+1)'(ent_r.size) - need_c);
        wr.data.used = 1'b0;
        state_nxt    = S_SPL_LO;
      end

      S_SPL_LO: begin
        wr.en        = 1'b1;
        wr.addr      = idx_r;
        wr.data.off  = ent_r.off;
        wr.data.size = SIZE_W'(size_r);
        wr.data.used = 1'b1;
        count_nxt    = count_r + CNT_W'(1);
        used_nxt     = used_r + SIZE_W'(size_r);
        free_nxt     = free_r - SIZE_W'(need_c);
        state_nxt    = S_DONE;
      end

      // Free: locate the block start
      S_FS_RD: begin
        rd_addr = j_r[IDX_W-1:0];
        if (j_r < count_r) begin
          state_nxt = S_FS_CHK;
        end else begin
          status_nxt = ST_BAD_ADDR;
          state_nxt  = S_DONE;
        end
      end

      S_FS_CHK: begin
        if (rd_data.off == start_r) begin
          ent_nxt   = rd_data;
          idx_nxt   = j_r[IDX_W-1:0];
          state_nxt = S_FP_RD;
        end else begin
          j_nxt     = j_r + CNT_W'(1);
          state_nxt = S_FS_RD;
        end
      end

      // Fetch neighbors
      S_FP_RD: begin
        rd_addr = idx_r - IDX_W'(1);
        if (idx_r != '0) begin
          state_nxt = S_FP_GET;
        end else begin
          pf_nxt    = 1'b0;
          state_nxt = S_FN_RD;
        end
      end

      S_FP_GET: begin
        prev_size_nxt = rd_data.size;
        prev_off_nxt  = rd_data.off;
        pf_nxt        = !rd_data.used;
        state_nxt     = S_FN_RD;
      end

      S_FN_RD: begin
        rd_addr = idx_r + IDX_W'(1);
        if (({1'b0, idx_r} + CNT_W'(1)) < count_r) begin
          state_nxt = S_FN_GET;
        end else begin
          nf_nxt    = 1'b0;
          state_nxt = S_MERGE;
        end
      end

      S_FN_GET: begin
        next_size_nxt = rd_data.size;
        nf_nxt        = !rd_data.used;
        state_nxt     = S_MERGE;
      end

      // Release and coalesce
      S_MERGE: begin
        used_nxt = used_r - s_used_c;
        free_nxt = free_r + s_used_c + (pf_r ? SIZE_W'(OVERHEAD) : '0)
                   + (nf_r ? SIZE_W'(OVERHEAD) : '0);
        wr.en        = 1'b1;
        wr.data.used = 1'b0;
        k_nxt        = (pf_r && nf_r) ? 2'd2 : 2'd1;
        if (pf_r) begin
          wr.addr      = idx_r - IDX_W'(1);
          wr.data.off  = prev_off_r;
          wr.data.size = prev_size_r + ent_r.size + SIZE_W'(OVERHEAD)
                         + (nf_r ? next_size_r + SIZE_W'(OVERHEAD) : '0);
          j_nxt        = {1'b0, idx_r};
          state_nxt    = S_SDN_RD;
        end else begin
          wr.addr      = idx_r;
          wr.data.off  = ent_r.off;
          wr.data.size = ent_r.size + (nf_r ? next_size_r + SIZE_W'(OVERHEAD) : '0);
          j_nxt        = {1'b0, idx_r} + CNT_W'(1);
          state_nxt    = nf_r ? S_SDN_RD : S_DONE;
        end
      end

      S_SDN_RD: begin
        rd_addr = IDX_W'(j_r + CNT_W'(k_r));
        if ((j_r + CNT_W'(k_r)) < count_r) begin
          state_nxt = S_SDN_WR;
        end else begin
          count_nxt = count_r - CNT_W'(k_r);
          state_nxt = S_DONE;
        end
      end

      S_SDN_WR: begin
        wr.en     = 1'b1;
        wr.addr   = j_r[IDX_W-1:0];
        wr.data   = rd_data;
        j_nxt     = j_r + CNT_W'(1);
        state_nxt = S_SDN_RD;
      end

      S_DONE: begin
        res.valid      = out_free;
        res.addr       = raddr_r;
        res.status     = status_r;
        res.free_bytes = free_r;
        res.used_bytes = used_r;
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_INIT;
      end
    endcase

    // A pool write rebuilds the table
    if (cfg_we) begin
      pool_nxt  = cfg_wdata;
      state_nxt = S_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      pool_r  <= POOL_RESET;
      count_r <= CNT_W'(1);
      free_r  <= '0;
      used_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pool_r  <= pool_nxt;
      count_r <= count_nxt;
      free_r  <= free_nxt;
      used_r  <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    size_r      <= size_nxt;
    start_r     <= start_nxt;
    f_r         <= f_nxt;
    f_ok_r      <= f_ok_nxt;
    b_r         <= b_nxt;
    b_ok_r      <= b_ok_nxt;
    idx_r       <= idx_nxt;
    j_r         <= j_nxt;
    k_r         <= k_nxt;
    ent_r       <= ent_nxt;
    prev_size_r <= prev_size_nxt;
    prev_off_r  <= prev_off_nxt;
    next_size_r <= next_size_nxt;
    pf_r        <= pf_nxt;
    nf_r        <= nf_nxt;
    raddr_r     <= raddr_nxt;
    status_r    <= status_nxt;
  end

endmodule

// ===== rtl/first_fit_pool_allocator.sv =====
// Channel  | Direction | Handshake         | Payload
// ---------+-----------+-------------------+---------------------------------------------
// in_      | input     | in_valid/in_stall | kind, req_size, addr
// out_     | output    | out_valid/out_stall | result_addr, status, free_bytes, used_bytes
// cfg_     | input     | cfg_we            | wdata (pool_bytes)
//
// One request at a time; the table sits in a single-port-read RAM, so every table
// read is split into an address state and a state that uses the registered data.
// Allocate rounds the size up, probes entries alternately from the front and the back,
// then grants, shifting entries up on a split; free scans for the block start, fetches
// both neighbors, merges, and shifts entries down. The table holds up to N = 64 entries.
// Reset and every cfg write spend one cycle rebuilding the table before in_stall drops.
// A held result in the output register stalls only the next completion, not acceptance.
module first_fit_pool_allocator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [ffpa_pkg::SIZE_W-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_kind,
  input  logic [ffpa_pkg::SIZE_W-1:0] in_req_size,
  input  logic [ffpa_pkg::OFF_W-1:0]  in_addr,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ffpa_pkg::OFF_W-1:0]  out_result_addr,
  output logic [1:0]                  out_status,
  output logic [ffpa_pkg::SIZE_W-1:0] out_free_bytes,
  output logic [ffpa_pkg::SIZE_W-1:0] out_used_bytes
);
  import ffpa_pkg::*;

  result_t          res;
  tbl_wr_t          wr;
  logic [IDX_W-1:0] rd_addr;
  logic [ENT_W-1:0] rd_raw;
  entry_t           rd_data;
  logic             out_free;

  logic              out_valid_r;
  logic [OFF_W-1:0]  addr_r;
  logic [1:0]        status_r;
  logic [SIZE_W-1:0] free_r;
  logic [SIZE_W-1:0] used_r;

  assign rd_data  = entry_t'(rd_raw);
  assign out_free = !out_valid_r || !out_stall;

  ffpa_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_kind     (in_kind),
    .in_req_size (in_req_size),
    .in_addr     (in_addr),
    .in_stall    (in_stall),
    .out_free    (out_free),
    .res         (res),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .wr          (wr)
  );

  ffpa_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_BLOCKS)
  ) u_tbl (
    .clk     (clk),
    .wr_en   (wr.en),
    .wr_addr (wr.addr),
    .wr_data (wr.data),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      addr_r   <= res.addr;
      status_r <= res.status;
      free_r   <= res.free_bytes;
      used_r   <= res.used_bytes;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_addr = addr_r;
  assign out_status      = status_r;
  assign out_free_bytes  = free_r;
  assign out_used_bytes  = used_r;

endmodule

// ===== rtl/ffpa_checker.sv =====
module ffpa_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [ffpa_pkg::OFF_W-1:0]  out_result_addr,
  input logic [1:0]                  out_status,
  input logic [ffpa_pkg::SIZE_W-1:0] out_free_bytes,
  input logic [ffpa_pkg::SIZE_W-1:0] out_used_bytes
);
  import ffpa_pkg::*;

  // Held transaction keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_addr)
      && $stable(out_status) && $stable(out_free_bytes) && $stable(out_used_bytes))
    else $error("output transaction changed while stalled");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK) || (out_status == ST_NOFIT)
      || (out_status == ST_BAD_ADDR))
    else $error("illegal status code");

  // Failures never report an address
  a_fail_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_result_addr == '0)
    else $error("failed request carries an address");

  // Payload totals can never exceed the largest pool size
  a_totals: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_free_bytes} + {1'b0, out_used_bytes}) <= {1'b0, POOL_MAX})
    else $error("free plus used exceeds the pool");

endmodule

bind first_fit_pool_allocator ffpa_checker u_ffpa_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_result_addr (out_result_addr),
  .out_status      (out_status),
  .out_free_bytes  (out_free_bytes),
  .out_used_bytes  (out_used_bytes)
);

// ===== tb/testbench.sv =====
module testbench;
  import ffpa_pkg::*;

  // Allocator state copy used to predict every result
  class pool_scoreboard;
    logic [OFF_W-1:0]  ent_off[MAX_BLOCKS];
    logic [SIZE_W-1:0] ent_size[MAX_BLOCKS];
    bit                ent_used[MAX_BLOCKS];
    int                n_ent;
    int unsigned       pool;
    logic [OFF_W-1:0]  exp_addr[$];
    logic [1:0]        exp_status[$];
    logic [SIZE_W-1:0] exp_free[$];
    logic [SIZE_W-1:0] exp_used[$];
    int                errors;
    int                n_ok, n_nofit, n_bad;

    function void rebuild(logic [SIZE_W-1:0] value);
      int unsigned p;
      p = value;
      if (p < OVERHEAD) p = OVERHEAD;
      if (p > 1048576) p = 1048576;
      pool = p;
      foreach (ent_off[i]) begin
        ent_off[i] = '0;
        ent_size[i] = '0;
        ent_used[i] = 0;
      end
      ent_size[0] = SIZE_W'(p - OVERHEAD);
      n_ent = 1;
    endfunction

    function void drop_entry(int i);
      for (int j = i; j + 1 < n_ent; j++) begin
        ent_off[j] = ent_off[j+1];
        ent_size[j] = ent_size[j+1];
        ent_used[j] = ent_used[j+1];
      end
      n_ent--;
    endfunction

    function bit bool_fits(int i, int unsigned sz);
      return !ent_used[i] && ent_size[i] >= sz;
    endfunction

    // Applies one accepted transaction and queues its expected result
    function void note_request(logic kind, logic [SIZE_W-1:0] req, logic [OFF_W-1:0] addr);
      logic [OFF_W-1:0] r_addr;
      logic [1:0]       st;
      int unsigned      sz, fsum, usum, start;
      int               f, b, hit, k;
      r_addr = '0;
      st = ST_OK;
      if (kind == KIND_ALLOC) begin
        if (req == 0) st = ST_NOFIT;
        else begin
          sz = ((int'(req) + ALIGN - 1) / ALIGN) * ALIGN;
          f = 0; b = n_ent - 1; hit = -1;
          while (f >= 0 || b >= 0) begin
            if (f >= 0) begin
              if (bool_fits(f, sz)) begin hit = f; break; end
              f = (f + 1 < n_ent) ? f + 1 : -1;
            end
            if (b >= 0 && b != f) begin
              if (bool_fits(b, sz)) begin hit = b; break; end
              b = b - 1;
            end
          end
          if (hit < 0) st = ST_NOFIT;
          else begin
            if (ent_size[hit] >= sz + OVERHEAD && n_ent < MAX_BLOCKS) begin
              for (int j = n_ent; j > hit + 1; j--) begin
                ent_off[j] = ent_off[j-1];
                ent_size[j] = ent_size[j-1];
                ent_used[j] = ent_used[j-1];
              end
              ent_off[hit+1] = OFF_W'(ent_off[hit] + OVERHEAD + sz);
              ent_size[hit+1] = SIZE_W'(ent_size[hit] - sz - OVERHEAD);
              ent_used[hit+1] = 0;
              ent_size[hit] = SIZE_W'(sz);
              n_ent++;
            end
            ent_used[hit] = 1;
            r_addr = OFF_W'(ent_off[hit] + HDR_SKIP);
          end
        end
      end else begin
        k = -1;
        if (addr >= HDR_SKIP) begin
          start = addr - HDR_SKIP;
          for (int i = 0; i < n_ent; i++)
            if (ent_off[i] == start) begin k = i; break; end
        end
        if (k < 0) st = ST_BAD_ADDR;
        else begin
          ent_used[k] = 0;
          if (k > 0 && !ent_used[k-1]) begin
            ent_size[k-1] = SIZE_W'(ent_size[k-1] + ent_size[k] + OVERHEAD);
            drop_entry(k);
            k--;
          end
          if (k + 1 < n_ent && !ent_used[k+1]) begin
            ent_size[k] = SIZE_W'(ent_size[k] + ent_size[k+1] + OVERHEAD);
            drop_entry(k + 1);
          end
        end
      end
      fsum = 0; usum = 0;
      for (int i = 0; i < n_ent; i++)
        if (ent_used[i]) usum += ent_size[i]; else fsum += ent_size[i];
      exp_addr.push_back(r_addr);
      exp_status.push_back(st);
      exp_free.push_back(SIZE_W'(fsum));
      exp_used.push_back(SIZE_W'(usum));
    endfunction

    function void report(string what, int unsigned got, int unsigned want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
      errors++;
    endfunction

    // Compares one accepted result with the oldest expectation
    function void check_result(logic [OFF_W-1:0] a, logic [1:0] st,
                               logic [SIZE_W-1:0] fb, logic [SIZE_W-1:0] ub);
      if (exp_status.size() == 0) begin
        $display("unexpected result at %0t", $time);
        errors++;
        return;
      end
      if (a !== exp_addr[0]) report("result_addr", a, exp_addr[0]);
      if (st !== exp_status[0]) report("status", st, exp_status[0]);
      if (fb !== exp_free[0]) report("free_bytes", fb, exp_free[0]);
      if (ub !== exp_used[0]) report("used_bytes", ub, exp_used[0]);
      case (exp_status[0])
        ST_OK:    n_ok++;
        ST_NOFIT: n_nofit++;
        default:  n_bad++;
      endcase
      void'(exp_addr.pop_front());
      void'(exp_status.pop_front());
      void'(exp_free.pop_front());
      void'(exp_used.pop_front());
    endfunction

    function int pending();
      return exp_status.size();
    endfunction
  endclass

  logic clk, rst_n;
  logic cfg_we;
  logic [SIZE_W-1:0] cfg_wdata;
  logic in_valid, in_stall, in_kind;
  logic [SIZE_W-1:0] in_req_size;
  logic [OFF_W-1:0] in_addr;
  logic out_valid, out_stall;
  logic [OFF_W-1:0] out_result_addr;
  logic [1:0] out_status;
  logic [SIZE_W-1:0] out_free_bytes, out_used_bytes;

  pool_scoreboard sb;
  int unsigned cycle;
  bit calm;                 // no idling in the final stretch
  logic [OFF_W-1:0] granted[$];
  int n_cfg;

  first_fit_pool_allocator uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_req_size(in_req_size), .in_addr(in_addr),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result_addr(out_result_addr), .out_status(out_status),
    .out_free_bytes(out_free_bytes), .out_used_bytes(out_used_bytes)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Result side: random stall bursts, check accepted transactions
  initial begin
    int burst;
    out_stall = 0;
    burst = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        sb.check_result(out_result_addr, out_status, out_free_bytes, out_used_bytes);
      if (burst > 0) burst--;
      else if (!calm && $urandom_range(0, 9) == 0) burst = $urandom_range(1, 8);
      out_stall <= (burst > 0);
    end
  end

  // Watchdog
  initial begin
    cycle = 0;
    forever begin
      @(posedge clk);
      cycle++;
      if (cycle > 3000000) begin
        $display("timeout after %0d cycles", cycle);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Sends one transaction; valid stays up until the next one or an idle gap
  task automatic send_req(logic kind, logic [SIZE_W-1:0] req, logic [OFF_W-1:0] addr);
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_kind <= kind;
    in_req_size <= req;
    in_addr <= addr;
    do @(posedge clk); while (in_stall);
    sb.note_request(kind, req, addr);
    if (kind == KIND_ALLOC && sb.exp_status[$] == ST_OK) granted.push_back(sb.exp_addr[$]);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (500) @(posedge clk);
  endtask

  task automatic write_pool(logic [SIZE_W-1:0] value);
    drain();
    cfg_we <= 1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 0;
    sb.rebuild(value);
    granted.delete();
    n_cfg++;
  endtask

  task automatic free_some();
    int k;
    k = $urandom_range(0, granted.size() - 1);
    send_req(KIND_FREE, '0, granted[k]);
    granted.delete(k);
  endtask

  // One random transaction, mostly well-formed alloc/free traffic
  task automatic random_req();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      if ($urandom_range(0, 9) == 0)
        send_req(KIND_ALLOC, SIZE_W'($urandom), OFF_W'($urandom));
      else
        send_req(KIND_ALLOC, SIZE_W'($urandom_range(1, sb.pool / 24 + 8)), OFF_W'($urandom));
    end else if (r < 88 && granted.size() > 0) free_some();
    else if (r < 94 && sb.n_ent > 1)
      send_req(KIND_FREE, SIZE_W'($urandom),
               OFF_W'(sb.ent_off[$urandom_range(0, sb.n_ent - 1)] + HDR_SKIP));
    else send_req(KIND_FREE, SIZE_W'($urandom), OFF_W'($urandom));
  endtask

  initial begin
    logic [SIZE_W-1:0] pools[6];
    sb = new();
    calm = 0;
    n_cfg = 0;
    rst_n = 0;
    cfg_we = 0;
    cfg_wdata = '0;
    in_valid = 0;
    in_kind = 0;
    in_req_size = '0;
    in_addr = '0;
    sb.rebuild(POOL_RESET);
    repeat (5) @(posedge clk);
    rst_n <= 1;

    // Directed: extremes, zero request, bad frees, double free, full table
    send_req(KIND_ALLOC, '0, '0);
    send_req(KIND_ALLOC, 21'd1, '0);
    send_req(KIND_ALLOC, 21'd7, '0);
    send_req(KIND_ALLOC, 21'd9, 20'hFFFFF);
    send_req(KIND_ALLOC, 21'h1FFFFF, '0);
    send_req(KIND_ALLOC, 21'd65504, '0);
    send_req(KIND_FREE, 21'h1FFFFF, '0);
    send_req(KIND_FREE, '0, 20'hFFFFF);
    send_req(KIND_FREE, '0, 20'd29);
    send_req(KIND_FREE, '0, 20'd28);
    send_req(KIND_FREE, '0, 20'd28);
    send_req(KIND_FREE, '0, 20'd92);
    send_req(KIND_FREE, '0, 20'd60);
    for (int i = 0; i < 70; i++) send_req(KIND_ALLOC, 21'd8, '0);
    // pause until all results are back
    drain();
    send_req(KIND_ALLOC, 21'd16, '0);
    for (int i = 0; i < 64; i += 3) send_req(KIND_FREE, '0, OFF_W'(sb.ent_off[i] + HDR_SKIP));

    // Random phases over several pool sizes, extremes included
    pools[0] = 21'd1000;   pools[1] = 21'd64;   pools[2] = 21'd0;
    pools[3] = 21'h1FFFFF; pools[4] = 21'd1048576; pools[5] = 21'd8192;
    for (int ph = 0; ph < 6; ph++) begin
      write_pool(ph == 5 ? SIZE_W'($urandom_range(64, 1048576)) : pools[ph]);
      if (ph == 5) calm = 0;
      for (int i = 0; i < 260; i++) begin
        if (ph == 5 && i == 200) calm = 1;
        random_req();
      end
    end
    send_req(KIND_ALLOC, 21'd40, '0);
    drain();

    $display("covered %0d pool settings: %0d ok, %0d no-fit, %0d bad-address results",
             n_cfg, sb.n_ok, sb.n_nofit, sb.n_bad);
    if (sb.errors == 0 && sb.pending() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
